[rtl/core/mesh_bounding_box_normalizer_top_assert.svh]
// Assertion macros for the bounding box normalizer top level.
// Depends on nothing; included by mesh_bounding_box_normalizer_top.sv.
`ifndef MESH_BOUNDING_BOX_NORMALIZER_TOP_ASSERT_SVH
`define MESH_BOUNDING_BOX_NORMALIZER_TOP_ASSERT_SVH
// implication checked every clock, quiet in reset
`define MBBN_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define MBBN_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[rtl/core/mbbn_pkg.sv]
// Package for the bounding box normalizer: widths, action codes, lane types.
// No dependencies.
package mbbn_pkg;
  localparam int CW = 32;
  localparam int OW = 31;
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ACCUM = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;
  localparam logic [1:0] ACT_NORM = 2'd3;
  localparam logic [63:0] HALF_Q30 = 64'd1 << 29;
  localparam logic [63:0] M_MAX = (64'd1 << 33) - 64'd1;
  localparam logic [63:0] R_NUM = (64'd1 << 62) - 64'd1;

  // latched scale parameters shared by all lanes
  typedef struct packed {
    logic [31:0] scale;
    logic [5:0]  sshift;
    logic [5:0]  rshift;
  } scale_t;
endpackage

[rtl/core/mesh_bounding_box_normalizer_top.sv]
// Bounding box normalizer: three axis lanes track min/max and normalize; a finish
// unit merges lane extents into a centre and 1/diagonal scale. Clear and accumulate
// give no beat; clear also drops the latched centre, scale and degenerate flag.
// Normalize runs through the lane multiplier stages and the output register (a
// degenerate box gives its beat in the cycle after acceptance). Finish works in
// steps: sum of squares over the three axes, one normalize shift per step (up to
// 31), a 32-step bitwise square root, a 63-step restoring divide, then an end state
// and the output register; an empty box or one of zero sum of squares ends early as
// degenerate. One beat is in flight at a time; the output register holds a result
// until taken and the input stalls meanwhile.
// Depends on mbbn_pkg, mbbn_lane, mbbn_finish.
module mesh_bounding_box_normalizer_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   s_tuser,   // action
  input  logic [95:0]  s_tdata,   // coord_x, coord_y, coord_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic         m_tuser,   // degenerate
  output logic [95:0]  m_tdata    // norm_x, norm_y, norm_z, zero pad
);
  import mbbn_pkg::*;
  logic acc_ok, busy_n, fin_busy, fin_done, degen;
  logic [1:0] npipe;
  logic signed [CW-1:0] lo [3], hi [3];
  logic signed [CW:0] mid2 [3];
  logic [OW-1:0] res [3];
  scale_t sc;
  logic go;
  logic clr_now;

  // finish hands its beat over in the done cycle, so hold the input then too
  assign s_tready = !m_tvalid && !fin_busy && !fin_done && npipe == 2'd0 && !busy_n;
  assign acc_ok = s_tvalid && s_tready;
  assign go = acc_ok && s_tuser == ACT_NORM && !degen;
  assign clr_now = acc_ok && s_tuser == ACT_CLEAR;

  genvar g;
  for (g = 0; g < 3; g++) begin : g_lane
    mbbn_lane u_lane (.clk, .rst, .clr(clr_now),
      .acc(acc_ok && s_tuser == ACT_ACCUM), .go,
      .v(s_tdata[32*g +: 32]), .mid2(mid2[g]), .sc, .lo(lo[g]), .hi(hi[g]),
      .res(res[g]));
  end

  // clear returns the latched centre, scale and degenerate flag to reset
  mbbn_finish u_fin (.clk, .rst(rst || clr_now), .start(acc_ok && s_tuser == ACT_FINISH),
    .lo, .hi, .busy(fin_busy), .done(fin_done), .degen, .mid2, .sc);

  always_ff @(posedge clk) begin
    if (rst || (acc_ok && s_tuser == ACT_CLEAR && !fin_busy)) begin
      npipe <= 2'd0;
      busy_n <= 1'b0;
      if (rst) m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      npipe <= {npipe[0], go};
      busy_n <= go;
      if (npipe[1]) begin
        m_tvalid <= 1'b1; m_tuser <= 1'b0;
        m_tdata <= {3'd0, res[2], res[1], res[0]};
      end
      if (fin_done || (acc_ok && s_tuser == ACT_NORM && degen)) begin
        m_tvalid <= 1'b1;
        m_tuser <= fin_done ? degen : 1'b1;
        m_tdata <= '0;
      end
    end
  end

  `include "mesh_bounding_box_normalizer_top_assert.svh"
  `MBBN_ASSERT_IMPL(a_no_take_busy, fin_busy, !s_tready)
  `MBBN_ASSERT_NEXT(a_hold_out, m_tvalid && !m_tready, m_tvalid)
  `MBBN_ASSERT_IMPL(a_no_overlap, npipe[1], !fin_done)
endmodule

[rtl/core/mbbn_lane.sv]
// One axis lane: extent tracking and normalize datapath (2 stages).
// Depends on mbbn_pkg.
module mbbn_lane (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clr,
  input  logic                     acc,
  input  logic                     go,
  input  logic signed [mbbn_pkg::CW-1:0] v,
  input  logic signed [mbbn_pkg::CW:0]   mid2,
  input  mbbn_pkg::scale_t         sc,
  output logic signed [mbbn_pkg::CW-1:0] lo,
  output logic signed [mbbn_pkg::CW-1:0] hi,
  output logic [mbbn_pkg::OW-1:0]  res
);
  import mbbn_pkg::*;
  logic [33:0] m1;
  logic        neg1, neg2;
  logic [65:0] prod;
  logic signed [CW+1:0] t;
  logic [CW+1:0] mag;
  logic [63:0] ms, p;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      lo <= {1'b0, {(CW-1){1'b1}}};
      hi <= {1'b1, {(CW-1){1'b0}}};
    end else if (acc) begin
      if (v < lo) lo <= v;
      if (v > hi) hi <= v;
    end
  end

  always_comb begin
    t = {v[CW-1], v, 1'b0} - {mid2[CW], mid2};
    mag = t[CW+1] ? (~t + 1'b1) : t;
    ms = {{(64-CW-2){1'b0}}, mag} >> sc.rshift;
    if (ms > M_MAX) ms = M_MAX;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m1 <= ms[33:0];
      neg1 <= t[CW+1];
    end
    prod <= m1 * sc.scale;
    neg2 <= neg1;
  end

  always_comb begin
    p = prod[63:0] >> sc.sshift;
    if (prod[65:64] != 2'd0 && sc.sshift < 6'd2) p = HALF_Q30;
    if (p > HALF_Q30) p = HALF_Q30;
    res = neg2 ? (~p[OW-1:0] + 1'b1) : p[OW-1:0];
  end
endmodule

[rtl/core/mbbn_finish.sv]
// Finish unit: merges lane extents into centre and scale (iterative sqrt, divide).
// Depends on mbbn_pkg.
module mbbn_finish (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [mbbn_pkg::CW-1:0] lo [3],
  input  logic signed [mbbn_pkg::CW-1:0] hi [3],
  output logic busy,
  output logic done,
  output logic degen,
  output logic signed [mbbn_pkg::CW:0] mid2 [3],
  output mbbn_pkg::scale_t sc
);
  import mbbn_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_SQ = 3'd1, S_NRM = 3'd2, S_SQRT = 3'd3,
                         S_DIV = 3'd4, S_END = 3'd5;
  logic [2:0] st;
  logic [CW:0] d [3];
  logic [CW:0] maxd;
  logic [5:0] r, k, cnt;
  logic [1:0] ax;
  logic [63:0] s, op, rs, one, rem, q;
  logic [63:0] dt, trial;
  logic [61:0] sq;
  logic bad;

  always_comb begin
    bad = 1'b0;
    maxd = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = {hi[i][CW-1], hi[i]} - {lo[i][CW-1], lo[i]};
      if (lo[i] > hi[i]) bad = 1'b1;
      if (d[i] > maxd) maxd = d[i];
    end
    r = maxd[CW] ? 6'd2 : (maxd[CW-1] ? 6'd1 : 6'd0);
    dt = {{(63-CW){1'b0}}, d[ax]} >> r;
    // shifted extent is below 2^31, so a 31 x 31 square
    sq = dt[30:0] * dt[30:0];
    trial = rs + one;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      st <= S_IDLE;
      degen <= 1'b1;
      sc <= '0;
      for (int i = 0; i < 3; i++) mid2[i] <= '0;
    end else begin
      case (st)
        S_IDLE: if (start) begin
          if (bad) begin
            degen <= 1'b1; sc <= '0;
            for (int i = 0; i < 3; i++) mid2[i] <= '0;
            st <= S_END;
          end else begin
            s <= '0; ax <= 2'd0; sc.rshift <= r; k <= '0; st <= S_SQ;
          end
        end
        S_SQ: begin
          s <= s + {2'b00, sq};
          if (ax == 2'd2) st <= S_NRM;
          ax <= ax + 2'd1;
        end
        S_NRM: begin
          if (s == 64'd0) begin
            degen <= 1'b1; sc <= '0;
            for (int i = 0; i < 3; i++) mid2[i] <= '0;
            st <= S_END;
          end else if (s < (64'd1 << 62)) begin
            s <= s << 2; k <= k + 6'd1;
          end else begin
            op <= s; rs <= '0; one <= 64'd1 << 62; st <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (op >= trial) begin
            op <= op - trial; rs <= (rs >> 1) + one;
          end else rs <= rs >> 1;
          one <= one >> 2;
          if (one[0]) begin
            st <= S_DIV; rem <= '0; q <= '0; cnt <= 6'd62;
          end
        end
        S_DIV: begin
          if ({rem[62:0], R_NUM[cnt]} >= {32'd0, rs[31:0]}) begin
            rem <= {rem[62:0], R_NUM[cnt]} - {32'd0, rs[31:0]};
            q <= {q[62:0], 1'b1};
          end else begin
            rem <= {rem[62:0], R_NUM[cnt]};
            q <= {q[62:0], 1'b0};
          end
          if (cnt == 6'd0) begin
            st <= S_END; degen <= 1'b0;
            sc.sshift <= 6'd33 - k;
            for (int i = 0; i < 3; i++) mid2[i] <= {lo[i][CW-1], lo[i]} + {hi[i][CW-1], hi[i]};
          end
          cnt <= cnt - 6'd1;
        end
        S_END: begin
          if (!degen) sc.scale <= q[31:0];
          done <= 1'b1; st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
  assign busy = (st != S_IDLE);
endmodule
